FILE: sv/sphk_pkg.sv
// ---------------------------------------------------------------------------
// sphk_pkg
// Shared types and constants of the cubic spline kernel weight/gradient block.
// ---------------------------------------------------------------------------
package sphk_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_LEN = 1'd1;

   localparam logic [30:0] NORM_GAIN_RST = 31'd65536;
   localparam logic [30:0] SMOOTH_LEN_RST = 31'd65536;

   localparam int DIMENSIONS = 3;
   localparam int NUM_AXES = 3;

   // q = r / h divider: one quotient bit per stage, Q2.30 result
   localparam int QDIV_STEPS = 32;
   localparam int QREM_W = 61;

   // gradient divider: overflow check stage, 31 bit stages, output stage
   localparam int GDIV_STEPS = 31;
   localparam int GDIV_LAT = GDIV_STEPS + 2;

   // front register + q divider + seven arithmetic stages + gradient divider
   localparam int PIPE_LAT = 1 + QDIV_STEPS + 7 + GDIV_LAT;

   localparam logic [31:0] TWO_THIRDS_Q30 = 32'd715827883;
   localparam logic [31:0] TWO_Q30 = 32'h8000_0000;
   localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;  // ceil(2^34 / 6)
   localparam int RECIP6_SH = 34;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic [NUM_AXES-1:0][31:0] disp;
      logic [30:0] pair_dist;
      logic inner;
      logic in_support;
   } ctx_type;

   typedef struct packed {
      logic pos;
      logic active;
   } gctl_type;

endpackage

FILE: sv/sphk_grad_div.sv
// ---------------------------------------------------------------------------
// sphk_grad_div
// One gradient component: floor(num * 2^16 / den), signed and saturated.
// ---------------------------------------------------------------------------
module sphk_grad_div (
   input  logic clock,
   input  logic adv,
   input  logic [63:0] num,
   input  logic [61:0] den,
   input  sphk_pkg::gctl_type ctl,
   output logic [31:0] grad
);

   localparam int STEPS = sphk_pkg::GDIV_STEPS;

   logic [79:0] rem_ff [0:STEPS];
   logic [STEPS-1:0] quo_ff [0:STEPS];
   logic [61:0] den_ff [0:STEPS];
   sphk_pkg::gctl_type ctl_ff [0:STEPS];
   logic sat_ff [0:STEPS];
   logic [31:0] grad_ff;
   logic [31:0] grad_in;
   logic [31:0] mag;

   // quotient >= 2^31 exactly when num >= den * 2^15
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= {num, 16'b0};
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         ctl_ff[0] <= ctl;
         sat_ff[0] <= {13'b0, num} >= {den, 15'b0};
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int B = STEPS - 1 - j;
      logic take;
      logic [79:0] sub;
      assign take = (rem_ff[j] >> B) >= {18'b0, den_ff[j]};
      assign sub = rem_ff[j] - ({18'b0, den_ff[j]} << B);
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= take ? sub : rem_ff[j];
            quo_ff[j+1] <= {quo_ff[j][STEPS-2:0], take};
            den_ff[j+1] <= den_ff[j];
            ctl_ff[j+1] <= ctl_ff[j];
            sat_ff[j+1] <= sat_ff[j];
         end
      end
   end

   assign mag = {1'b0, quo_ff[STEPS]};

   always_comb begin
      if (!ctl_ff[STEPS].active) begin
         grad_in = '0;
      end else if (ctl_ff[STEPS].pos) begin
         grad_in = sat_ff[STEPS] ? sphk_pkg::NEG_MAX : (32'd0 - mag);
      end else begin
         grad_in = sat_ff[STEPS] ? sphk_pkg::POS_MAX : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grad_ff <= grad_in;
      end
   end

   assign grad = grad_ff;

endmodule

FILE: sv/sph_cubic_kernel_weight_grad.sv
// ---------------------------------------------------------------------------
// sph_cubic_kernel_weight_grad
// Cubic spline SPH kernel weight and gradient for one particle pair per beat.
// ---------------------------------------------------------------------------
// Fully pipelined: a pair is accepted every cycle unless a result is held on
// rsp. The depth is set by two bit-per-stage dividers in series: 32 stages
// for q = r / h and 33 for the gradient division by h*h or h*r, with seven
// arithmetic stages between them. A result held on rsp stalls the whole
// pipeline; nothing is lost or repeated. Configuration is taken any time but
// must only change while no pair is in flight.
module sph_cubic_kernel_weight_grad (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // disp_x, disp_y, disp_z, pair_distance (31b), 1b pad
   input  logic [127:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // kernel_weight, grad_x, grad_y, grad_z
   output logic [127:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sphk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);

   localparam int QS = sphk_pkg::QDIV_STEPS;
   localparam int QW = sphk_pkg::QREM_W;
   localparam int NA = sphk_pkg::NUM_AXES;
   localparam int PL = sphk_pkg::PIPE_LAT;
   localparam int GL = sphk_pkg::GDIV_LAT;

   logic [30:0] norm_ff, hlen_ff;
   logic [PL-1:0] vld_ff;
   logic adv;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff <= sphk_pkg::NORM_GAIN_RST;
         hlen_ff <= sphk_pkg::SMOOTH_LEN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            sphk_pkg::CSR_NORM_GAIN: norm_ff <= csr_data[30:0];
            sphk_pkg::CSR_SMOOTH_LEN: hlen_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   assign adv = !vld_ff[PL-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PL-2:0], req_tvalid};
      end
   end

   // ---------------- front register + q = r/h divider ----------------
   logic [QW-1:0] dq_rem_ff [0:QS];
   logic [31:0] dq_quo_ff [0:QS];
   sphk_pkg::ctx_type dq_ctx_ff [0:QS];
   sphk_pkg::ctx_type ctx_in;

   always_comb begin
      ctx_in.disp[0] = req_tdata[31:0];
      ctx_in.disp[1] = req_tdata[63:32];
      ctx_in.disp[2] = req_tdata[95:64];
      ctx_in.pair_dist = req_tdata[126:96];
      ctx_in.inner = req_tdata[126:96] <= hlen_ff;
      ctx_in.in_support = (hlen_ff != '0) &&
                          ({1'b0, req_tdata[126:96]} <= {hlen_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dq_rem_ff[0] <= {req_tdata[126:96], 30'b0};
         dq_quo_ff[0] <= '0;
         dq_ctx_ff[0] <= ctx_in;
      end
   end

   for (genvar j = 0; j < QS; j++) begin : g_qdiv
      localparam int B = QS - 1 - j;
      logic take;
      logic [QW:0] sub;
      assign take = (dq_rem_ff[j] >> B) >= {30'b0, hlen_ff};
      assign sub = {1'b0, dq_rem_ff[j]} - ({31'b0, hlen_ff} << B);
      always_ff @(posedge clock) begin
         if (adv) begin
            dq_rem_ff[j+1] <= take ? sub[QW-1:0] : dq_rem_ff[j];
            dq_quo_ff[j+1] <= {dq_quo_ff[j][30:0], take};
            dq_ctx_ff[j+1] <= dq_ctx_ff[j];
         end
      end
   end

   // ---------------- polynomial stages ----------------
   logic [31:0] q30;
   logic [33:0] q30x3;
   logic [30:0] p1_v_in, p1_v_ff;
   logic [31:0] p1_c_ff;
   logic [61:0] p1_den_ff;
   sphk_pkg::ctx_type p1_ctx_ff;

   assign q30 = dq_quo_ff[QS];
   assign q30x3 = {2'b0, q30} + {1'b0, q30, 1'b0};
   // inner: q; outer: 2 - q (both at most 1.0 in Q30)
   assign p1_v_in = dq_ctx_ff[QS].inner ? q30[30:0] : 31'(sphk_pkg::TWO_Q30 - q30);

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_v_ff <= p1_v_in;
         p1_c_ff <= sphk_pkg::TWO_Q30 - q30x3[32:1];
         p1_den_ff <= {31'b0, hlen_ff} *
                      {31'b0, (dq_ctx_ff[QS].inner ? hlen_ff : dq_ctx_ff[QS].pair_dist)};
         p1_ctx_ff <= dq_ctx_ff[QS];
      end
   end

   logic [61:0] p2_vsq_ff, p2_den_ff;
   logic [30:0] p2_v_ff;
   logic [31:0] p2_c_ff;
   sphk_pkg::ctx_type p2_ctx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_vsq_ff <= {31'b0, p1_v_ff} * {31'b0, p1_v_ff};
         p2_v_ff <= p1_v_ff;
         p2_c_ff <= p1_c_ff;
         p2_den_ff <= p1_den_ff;
         p2_ctx_ff <= p1_ctx_ff;
      end
   end

   logic [30:0] p3_v2_ff;
   logic [61:0] p3_prod_ff, p3_den_ff;
   logic [31:0] p3_c_ff;
   sphk_pkg::ctx_type p3_ctx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_v2_ff <= p2_vsq_ff[60:30];
         p3_prod_ff <= {31'b0, p2_vsq_ff[60:30]} * {31'b0, p2_v_ff};
         p3_c_ff <= p2_c_ff;
         p3_den_ff <= p2_den_ff;
         p3_ctx_ff <= p2_ctx_ff;
      end
   end

   logic [30:0] v3;
   logic [31:0] f_in;
   logic [30:0] p4_wop_ff;
   logic [31:0] p4_kop_ff;
   logic [61:0] p4_den_ff;
   sphk_pkg::ctx_type p4_ctx_ff;

   assign v3 = p3_prod_ff[60:30];
   // 2/3 - q^2 + q^3/2, positive for q in [0,1]
   assign f_in = sphk_pkg::TWO_THIRDS_Q30 - {1'b0, p3_v2_ff} + {2'b0, v3[30:1]};

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_wop_ff <= p3_ctx_ff.inner ? f_in[30:0] : v3;
         p4_kop_ff <= p3_ctx_ff.inner ? p3_c_ff : {2'b0, p3_v2_ff[30:1]};
         p4_den_ff <= p3_den_ff;
         p4_ctx_ff <= p3_ctx_ff;
      end
   end

   logic [61:0] p5_wprod_ff, p5_den_ff;
   logic [62:0] p5_kprod_ff;
   sphk_pkg::ctx_type p5_ctx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_wprod_ff <= {31'b0, norm_ff} * {31'b0, p4_wop_ff};
         p5_kprod_ff <= {32'b0, norm_ff} * {31'b0, p4_kop_ff};
         p5_den_ff <= p4_den_ff;
         p5_ctx_ff <= p4_ctx_ff;
      end
   end

   logic [31:0] p6_wsh_ff, p6_k_ff;
   logic [63:0] p6_wrec_ff;
   logic [61:0] p6_den_ff;
   sphk_pkg::ctx_type p6_ctx_ff;

   // outer weight divides by 6 through a reciprocal multiply
   always_ff @(posedge clock) begin
      if (adv) begin
         p6_wsh_ff <= p5_wprod_ff[61:30];
         p6_wrec_ff <= {32'b0, p5_wprod_ff[61:30]} * {32'b0, sphk_pkg::RECIP6};
         p6_k_ff <= p5_kprod_ff[61:30];
         p6_den_ff <= p5_den_ff;
         p6_ctx_ff <= p5_ctx_ff;
      end
   end

   logic [31:0] wsel, wsat, w_in;
   logic [31:0] p7_w_ff;
   logic [61:0] p7_den_ff;
   logic [NA-1:0][63:0] p7_num_ff;
   sphk_pkg::gctl_type p7_ctl_ff [0:NA-1];

   assign wsel = p6_ctx_ff.inner ? p6_wsh_ff
                                 : {2'b0, p6_wrec_ff[63:sphk_pkg::RECIP6_SH]};
   assign wsat = (wsel > sphk_pkg::POS_MAX) ? sphk_pkg::POS_MAX : wsel;
   assign w_in = p6_ctx_ff.in_support ? wsat : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_w_ff <= w_in;
         p7_den_ff <= p6_den_ff;
      end
   end

   for (genvar a = 0; a < NA; a++) begin : g_axis
      logic [31:0] dabs;
      assign dabs = p6_ctx_ff.disp[a][31] ? (32'd0 - p6_ctx_ff.disp[a]) : p6_ctx_ff.disp[a];
      always_ff @(posedge clock) begin
         if (adv) begin
            p7_num_ff[a] <= {32'b0, p6_k_ff} * {32'b0, dabs};
            p7_ctl_ff[a].pos <= !p6_ctx_ff.disp[a][31];
            p7_ctl_ff[a].active <= p6_ctx_ff.in_support && (a < sphk_pkg::DIMENSIONS);
         end
      end
   end

   // ---------------- gradient dividers ----------------
   logic [NA-1:0][31:0] grad;

   for (genvar a = 0; a < NA; a++) begin : g_gdiv
      sphk_grad_div u_gdiv (
         .clock (clock),
         .adv   (adv),
         .num   (p7_num_ff[a]),
         .den   (p7_den_ff),
         .ctl   (p7_ctl_ff[a]),
         .grad  (grad[a])
      );
   end

   // weight waits alongside the gradient dividers
   logic [31:0] w_dly_ff [0:GL-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         w_dly_ff[0] <= p7_w_ff;
      end
   end

   for (genvar i = 1; i < GL; i++) begin : g_wdly
      always_ff @(posedge clock) begin
         if (adv) begin
            w_dly_ff[i] <= w_dly_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[PL-1];
   assign rsp_tdata = {grad[2], grad[1], grad[0], w_dly_ff[GL-1]};

endmodule

FILE: sv/sphk_checker.sv
// ---------------------------------------------------------------------------
// sphk_checker
// Port-level checks of the kernel block, bound to the top level.
// ---------------------------------------------------------------------------
module sphk_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [127:0] rsp_tdata
);

   // held result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // weight is never negative
   a_weight_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("negative kernel weight");

   // an empty output never blocks input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sph_cubic_kernel_weight_grad sphk_checker u_sphk_checker (.*);
